[sv/rmq_pkg.sv]
`timescale 1ns / 1ps
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;

	// root pipeline: one result bit per stage, then a rounding stage
	localparam int SQ_IN_W   = 32;
	localparam int SQ_ROOT_W = 16;
	localparam int SQ_REM_W  = SQ_ROOT_W + 4;
	localparam int SQ_LAT    = SQ_ROOT_W + 1;

	// divider pipeline: one setup stage, then one quotient bit per stage
	localparam int DV_MAG_W = 17;
	localparam int DV_N_W   = 32;
	localparam int DV_D_W   = SQ_ROOT_W + 1;
	localparam int DV_Q_W   = FRAC_BITS + 1;
	localparam int DV_LAT   = DV_Q_W + 1;

	localparam int PIPE_LAT = 1 + SQ_LAT + DV_LAT + 1;

	localparam logic [1:0] CASE_TRACE = 2'd0;
	localparam logic [1:0] CASE_X     = 2'd1;
	localparam logic [1:0] CASE_Y     = 2'd2;
	localparam logic [1:0] CASE_Z     = 2'd3;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic [1:0]         case_taken;
		logic               degenerate;
	} quat_t;

	// saturate a quotient to one and apply the sign of the difference
	function automatic logic signed [15:0] fin_part(logic [DV_Q_W-1:0] q, logic ovf,
			logic neg);
		logic [DV_Q_W-1:0] mag;
		mag = (ovf || (q > DV_Q_W'(ONE))) ? DV_Q_W'(ONE) : q;
		return neg ? -(16'(mag)) : 16'(mag);
	endfunction

endpackage

[sv/rmq_sqrt.sv]
`timescale 1ns / 1ps
module rmq_sqrt import rmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_in,
	input  logic [SQ_IN_W-1:0]   n,
	output logic                 vld_out,
	output logic [SQ_ROOT_W-1:0] r
);

	logic                 vld_s  [SQ_ROOT_W];
	logic [SQ_REM_W-1:0]  rem_s  [SQ_ROOT_W];
	logic [SQ_ROOT_W-1:0] root_s [SQ_ROOT_W];
	logic [SQ_IN_W-1:0]   nr_s   [SQ_ROOT_W];

	genvar g;
	generate
		for (g = 0; g < SQ_ROOT_W; g++) begin : g_step
			logic                 pv;
			logic [SQ_REM_W-1:0]  prem, rem_t, trial, rem_n;
			logic [SQ_ROOT_W-1:0] proot, root_n;
			logic [SQ_IN_W-1:0]   pnr;

			if (g == 0) begin : g_first
				assign pv    = vld_in;
				assign prem  = '0;
				assign proot = '0;
				assign pnr   = n;
			end else begin : g_next
				assign pv    = vld_s[g-1];
				assign prem  = rem_s[g-1];
				assign proot = root_s[g-1];
				assign pnr   = nr_s[g-1];
			end

			// bring down two bits, try root*4+1
			always_comb begin
				rem_t = {prem[SQ_REM_W-3:0], pnr[SQ_IN_W-1 -: 2]};
				trial = {(SQ_REM_W-SQ_ROOT_W-2)'(0), proot, 2'b01};
				if (rem_t >= trial) begin
					rem_n  = rem_t - trial;
					root_n = {proot[SQ_ROOT_W-2:0], 1'b1};
				end else begin
					rem_n  = rem_t;
					root_n = {proot[SQ_ROOT_W-2:0], 1'b0};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[g] <= 1'b0;
				else         vld_s[g] <= pv;
			end

			always_ff @(posedge clk) begin
				rem_s[g]  <= rem_n;
				root_s[g] <= root_n;
				nr_s[g]   <= {pnr[SQ_IN_W-3:0], 2'b00};
			end
		end
	endgenerate

	// round to nearest: step up when the remainder exceeds the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else         vld_out <= vld_s[SQ_ROOT_W-1];
	end

	always_ff @(posedge clk) begin
		r <= root_s[SQ_ROOT_W-1] + SQ_ROOT_W'(rem_s[SQ_ROOT_W-1] >
			{(SQ_REM_W-SQ_ROOT_W)'(0), root_s[SQ_ROOT_W-1]});
	end

endmodule

[sv/rmq_div.sv]
`timescale 1ns / 1ps
module rmq_div import rmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_in,
	input  logic [DV_MAG_W-1:0]  mag,
	input  logic [SQ_ROOT_W-1:0] r,
	output logic                 vld_out,
	output logic [DV_Q_W-1:0]    q,
	output logic                 ovf
);

	logic [DV_N_W-1:0] num;
	logic [DV_D_W-1:0] den;

	logic              vld_s0;
	logic [DV_N_W-1:0] rem_s0;
	logic [DV_D_W-1:0] den_s0;
	logic              ovf_s0;

	logic              vld_s  [DV_Q_W];
	logic [DV_N_W-1:0] rem_s  [DV_Q_W];
	logic [DV_D_W-1:0] den_s  [DV_Q_W];
	logic              ovf_s  [DV_Q_W];
	logic [DV_Q_W-1:0] quo_s  [DV_Q_W];

	// (mag * ONE + r) / (2r), rounded by the added r
	assign num = DV_N_W'({mag, FRAC_BITS'(0)}) + DV_N_W'(r);
	assign den = {r, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else         vld_s0 <= vld_in;
	end

	// a quotient that needs more bits than kept saturates anyway
	always_ff @(posedge clk) begin
		rem_s0 <= num;
		den_s0 <= den;
		ovf_s0 <= num >= (DV_N_W'(den) << DV_Q_W);
	end

	genvar g;
	generate
		for (g = 0; g < DV_Q_W; g++) begin : g_step
			localparam int B = DV_Q_W - 1 - g;
			logic              pv, povf;
			logic [DV_N_W-1:0] prem, sub;
			logic [DV_D_W-1:0] pden;
			logic [DV_Q_W-1:0] pquo;

			if (g == 0) begin : g_first
				assign pv   = vld_s0;
				assign prem = rem_s0;
				assign pden = den_s0;
				assign povf = ovf_s0;
				assign pquo = '0;
			end else begin : g_next
				assign pv   = vld_s[g-1];
				assign prem = rem_s[g-1];
				assign pden = den_s[g-1];
				assign povf = ovf_s[g-1];
				assign pquo = quo_s[g-1];
			end

			assign sub = DV_N_W'(pden) << B;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[g] <= 1'b0;
				else         vld_s[g] <= pv;
			end

			always_ff @(posedge clk) begin
				den_s[g] <= pden;
				ovf_s[g] <= povf;
				if (prem >= sub) begin
					rem_s[g] <= prem - sub;
					quo_s[g] <= pquo | (DV_Q_W'(1) << B);
				end else begin
					rem_s[g] <= prem;
					quo_s[g] <= pquo;
				end
			end
		end
	endgenerate

	assign vld_out = vld_s[DV_Q_W-1];
	assign q       = quo_s[DV_Q_W-1];
	assign ovf     = ovf_s[DV_Q_W-1];

endmodule

[sv/rotation_matrix_to_quaternion.sv]
`timescale 1ns / 1ps
// channel   ports                     handshake
// -------   -----------------------   ----------------------------------------
// in        start, busy, matrix       item taken when start is high, busy low
// out       done, quat                item shown for one cycle while done high
//
// One item may enter every cycle. The depth is the bit-serial root (16 stages
// plus rounding) followed by three parallel long dividers (setup plus 15
// stages), with one select stage in front and one output register behind.
// busy never rises. Reset clears all valid bits; items in flight are dropped.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  mat_t  matrix,
	output logic  done,
	output quat_t quat
);

	typedef struct packed {
		logic [1:0]         cs;
		logic               degen;
		logic signed [16:0] da;
		logic signed [16:0] db;
		logic signed [16:0] dc;
	} side1_t;

	typedef struct packed {
		logic [1:0]  cs;
		logic        degen;
		logic [15:0] main;
		logic        na;
		logic        nb;
		logic        nc;
	} side2_t;

	logic signed [17:0] e00, e11, e22, trace, arg;
	logic signed [16:0] da, db, dc;
	logic [1:0]         cs;
	logic               degen;
	logic               big1;

	logic               vld_s1;
	logic [SQ_IN_W-1:0] n_s1;
	side1_t             side_s1;

	side1_t side1_s [SQ_LAT];
	side2_t side2_s [DV_LAT];

	logic                 sq_vld;
	logic [SQ_ROOT_W-1:0] sq_r;
	logic [16:0]          main_full;
	logic [15:0]          main_sat;
	side1_t               sd1;
	side2_t               sd2;

	logic [DV_MAG_W-1:0] mag_a, mag_b, mag_c;
	logic                va, vb, vc;
	logic [DV_Q_W-1:0]   qa, qb, qc;
	logic                oa, ob, oc;
	logic signed [15:0]  pa, pb, pc, pm;

	logic  done_q;
	quat_t quat_q;

	assign busy = 1'b0;

	assign e00   = 18'(matrix.m00);
	assign e11   = 18'(matrix.m11);
	assign e22   = 18'(matrix.m22);
	assign trace = e00 + e11 + e22;
	assign big1  = matrix.m11 > matrix.m00;

	// pick the branch and the three differences that feed the dividers
	always_comb begin
		arg = '0;
		da  = '0;
		db  = '0;
		dc  = '0;
		if (trace > 0) begin
			cs = CASE_TRACE;
		end else if (matrix.m22 > (big1 ? matrix.m11 : matrix.m00)) begin
			cs = CASE_Z;
		end else if (big1) begin
			cs = CASE_Y;
		end else begin
			cs = CASE_X;
		end
		case (cs)
			CASE_TRACE: begin
				arg = trace + 18'(ONE);
				da  = 17'(matrix.m21) - 17'(matrix.m12);
				db  = 17'(matrix.m02) - 17'(matrix.m20);
				dc  = 17'(matrix.m10) - 17'(matrix.m01);
			end
			CASE_X: begin
				arg = e00 - e11 - e22 + 18'(ONE);
				da  = 17'(matrix.m21) - 17'(matrix.m12);
				db  = 17'(matrix.m10) + 17'(matrix.m01);
				dc  = 17'(matrix.m20) + 17'(matrix.m02);
			end
			CASE_Y: begin
				arg = e11 - e22 - e00 + 18'(ONE);
				da  = 17'(matrix.m02) - 17'(matrix.m20);
				db  = 17'(matrix.m21) + 17'(matrix.m12);
				dc  = 17'(matrix.m01) + 17'(matrix.m10);
			end
			CASE_Z: begin
				arg = e22 - e00 - e11 + 18'(ONE);
				da  = 17'(matrix.m10) - 17'(matrix.m01);
				db  = 17'(matrix.m02) + 17'(matrix.m20);
				dc  = 17'(matrix.m12) + 17'(matrix.m21);
			end
			default: ;
		endcase
		degen = arg <= 0;
		if (degen) arg = 18'sd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		n_s1    <= {1'b0, arg[16:0], FRAC_BITS'(0)};
		side_s1 <= '{cs: cs, degen: degen, da: da, db: db, dc: dc};
	end

	rmq_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.n       (n_s1),
		.vld_out (sq_vld),
		.r       (sq_r)
	);

	// carry branch data alongside the root and divider pipelines
	always_ff @(posedge clk) begin
		side1_s[0] <= side_s1;
		for (int k = 1; k < SQ_LAT; k++) side1_s[k] <= side1_s[k-1];
		side2_s[0] <= sd2;
		for (int k = 1; k < DV_LAT; k++) side2_s[k] <= side2_s[k-1];
	end

	assign sd1       = side1_s[SQ_LAT-1];
	assign main_full = (17'(sq_r) + 17'd1) >> 1;
	assign main_sat  = (main_full > 17'(ONE)) ? 16'(ONE) : main_full[15:0];
	assign sd2       = '{cs: sd1.cs, degen: sd1.degen, main: main_sat,
		na: sd1.da[16], nb: sd1.db[16], nc: sd1.dc[16]};

	assign mag_a = sd1.da[16] ? DV_MAG_W'(-sd1.da) : DV_MAG_W'(sd1.da);
	assign mag_b = sd1.db[16] ? DV_MAG_W'(-sd1.db) : DV_MAG_W'(sd1.db);
	assign mag_c = sd1.dc[16] ? DV_MAG_W'(-sd1.dc) : DV_MAG_W'(sd1.dc);

	rmq_div u_div_a (.clk(clk), .arst_n(arst_n), .vld_in(sq_vld), .mag(mag_a), .r(sq_r),
		.vld_out(va), .q(qa), .ovf(oa));
	rmq_div u_div_b (.clk(clk), .arst_n(arst_n), .vld_in(sq_vld), .mag(mag_b), .r(sq_r),
		.vld_out(vb), .q(qb), .ovf(ob));
	rmq_div u_div_c (.clk(clk), .arst_n(arst_n), .vld_in(sq_vld), .mag(mag_c), .r(sq_r),
		.vld_out(vc), .q(qc), .ovf(oc));

	assign pa = fin_part(qa, oa, side2_s[DV_LAT-1].na);
	assign pb = fin_part(qb, ob, side2_s[DV_LAT-1].nb);
	assign pc = fin_part(qc, oc, side2_s[DV_LAT-1].nc);
	assign pm = side2_s[DV_LAT-1].main;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= va & vb & vc;
	end

	// place the parts by branch
	always_ff @(posedge clk) begin
		quat_q.case_taken <= side2_s[DV_LAT-1].cs;
		quat_q.degenerate <= side2_s[DV_LAT-1].degen;
		case (side2_s[DV_LAT-1].cs)
			CASE_TRACE: begin
				quat_q.qx <= pa; quat_q.qy <= pb; quat_q.qz <= pc; quat_q.qw <= pm;
			end
			CASE_X: begin
				quat_q.qx <= pm; quat_q.qy <= pb; quat_q.qz <= pc; quat_q.qw <= pa;
			end
			CASE_Y: begin
				quat_q.qx <= pc; quat_q.qy <= pm; quat_q.qz <= pb; quat_q.qw <= pa;
			end
			CASE_Z: begin
				quat_q.qx <= pb; quat_q.qy <= pc; quat_q.qz <= pm; quat_q.qw <= pa;
			end
			default: begin
				quat_q.qx <= pa; quat_q.qy <= pb; quat_q.qz <= pc; quat_q.qw <= pm;
			end
		endcase
	end

	assign done = done_q;
	assign quat = quat_q;

endmodule

[sv/rmq_checker.sv]
`timescale 1ns / 1ps
module rmq_checker import rmq_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  start,
	input logic  busy,
	input logic  done,
	input quat_t quat
);

	// every item taken comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("item taken without a result after the pipeline latency");

	// the part taken from the root is always positive
	a_main_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((quat.case_taken == CASE_TRACE && quat.qw > 0) ||
			(quat.case_taken == CASE_X && quat.qx > 0) ||
			(quat.case_taken == CASE_Y && quat.qy > 0) ||
			(quat.case_taken == CASE_Z && quat.qz > 0)))
		else $error("root part not positive");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat.qx <= 16'sd16384 && quat.qx >= -16'sd16384 &&
			quat.qy <= 16'sd16384 && quat.qy >= -16'sd16384 &&
			quat.qz <= 16'sd16384 && quat.qz >= -16'sd16384 &&
			quat.qw <= 16'sd16384 && quat.qw >= -16'sd16384))
		else $error("quaternion part outside saturation range");

	// a positive trace always gives a positive root argument
	a_trace_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && quat.case_taken == CASE_TRACE) |-> !quat.degenerate)
		else $error("degenerate flag on positive trace");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.quat   (quat)
);
